FILE: rtl/core/encoder_rpm_pid_pwm_drive_macros.svh
// assertion macros used by the drive rtl
`ifndef ENCODER_RPM_PID_PWM_DRIVE_MACROS_SVH
`define ENCODER_RPM_PID_PWM_DRIVE_MACROS_SVH
`ifndef SYNTHESIS
`define ERPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erpd assertion failed");
`define ERPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erpd assertion failed");
`else
`define ERPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ERPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/erpd_pkg.sv
`default_nettype none
package erpd_pkg;

   localparam int PWM_FULL_SCALE = 255;
   localparam int SPEED_SCALE    = 60000;
   localparam int SPEED_MAX      = 32767;
   localparam int DUTY_MAX       = 255;

   localparam int CPR_W      = 16;
   localparam int MR_W       = 15;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CNT_W  = 32;
   localparam int TIME_W = 32;
   localparam int RPM_W  = 16;
   localparam int ERR_W  = 17;
   localparam int DIFF_W = 18;
   localparam int SUM_W  = 32;

   localparam int PWM_W     = $clog2(PWM_FULL_SCALE + 1) + 1;
   localparam int PWM_OUT_W = 9;
   localparam int DUTY_W    = 8;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int S_W     = MR_W + 11;

   localparam int NUM_W  = 48;
   localparam int DEN_W  = 48;
   localparam int QUO_W  = 16;
   localparam int DSH_W  = DEN_W + QUO_W;
   localparam int STEP_W = $clog2(QUO_W + 1);

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_REV = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RPM        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN     = 3'd4;

   localparam logic [CPR_W-1:0] CPR_RESET = 16'd1000;
   localparam logic [MR_W-1:0]  MR_RESET  = 15'd330;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPD_NUM,
      ST_SPD_DEN,
      ST_SPD_START,
      ST_SPD_WAIT,
      ST_PID_ERR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_D,
      ST_CLAMP_S,
      ST_MUL_S,
      ST_MUL_PWM,
      ST_MUL_LIM,
      ST_CLAMP_X,
      ST_PWM_START,
      ST_PWM_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             ovf;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/erpd_mul.sv
`default_nettype none
module erpd_mul (
   input  logic                                 clock,
   input  erpd_pkg::mul_op_type                 op,
   output logic signed [erpd_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [erpd_pkg::PROD_W-1:0] prod_in;

   assign prod_in = $signed(op.a) * $signed(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/erpd_div.sv
`default_nettype none
module erpd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  erpd_pkg::div_req_type req,
   output erpd_pkg::div_rsp_type rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           ovf_ff, ovf_in;
   logic [erpd_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [erpd_pkg::NUM_W-1:0]     rem_ff, rem_in;
   logic [erpd_pkg::DSH_W-1:0]     dsh_ff, dsh_in;
   logic [erpd_pkg::QUO_W-1:0]     quo_ff, quo_in;

   logic [erpd_pkg::DSH_W-1:0]     rem_ext;
   logic [erpd_pkg::DSH_W-1:0]     rem_sub;
   logic                           ge;

   assign rem_ext = erpd_pkg::DSH_W'(rem_ff);
   assign ge      = rem_ext >= dsh_ff;
   assign rem_sub = rem_ext - dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      priority if (req.start) begin
         busy_in = 1'b1;
         step_in = erpd_pkg::STEP_W'(erpd_pkg::QUO_W);
         rem_in  = req.num;
         dsh_in  = {req.den, {erpd_pkg::QUO_W{1'b0}}};
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         // top step only checks whether the quotient fits
         if (step_ff == erpd_pkg::STEP_W'(erpd_pkg::QUO_W)) begin
            ovf_in = ge;
         end else begin
            if (ge) begin
               rem_in = rem_sub[erpd_pkg::NUM_W-1:0];
            end
            quo_in = {quo_ff[erpd_pkg::QUO_W-2:0], ge};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff  <= ovf_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quo  = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/core/encoder_rpm_pid_pwm_drive.sv
// Speed loop for one motor: each request carries an encoder count, a millisecond
// timestamp and a target rpm, and yields one response with the signed pwm, its duty,
// the direction pin levels, the measured rpm and a flag for a zero time interval.
// One shared signed multiplier and one 17-step restoring divider do all the
// multiplication and division under a sequencer. A new request is accepted only
// in the idle state, once the previous one has been loaded into the response
// register; the speed division is skipped when the elapsed time is zero.
// The response register lets the next request in while a response waits.
// Configuration is to be written by the user only while idle; no logic enforces it.
`default_nettype none
`include "encoder_rpm_pid_pwm_drive_macros.svh"
module encoder_rpm_pid_pwm_drive (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // encoder_count [31:0], time_ms [63:32], target_rpm [79:64]
   input  logic [erpd_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pwm_signed [8:0], duty [16:9], dir_a [17], dir_b [18], measured_rpm [34:19]
   output logic [erpd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // zero_interval [0]
   output logic [erpd_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  logic                                   csr_wen,
   input  logic [erpd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [erpd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   erpd_pkg::state_type state_ff, state_in;

   logic [erpd_pkg::CPR_W-1:0]          cpr_ff, cpr_in;
   logic [erpd_pkg::MR_W-1:0]           mr_ff, mr_in;
   logic [erpd_pkg::GAIN_W-1:0]         kp_ff, kp_in;
   logic [erpd_pkg::GAIN_W-1:0]         ki_ff, ki_in;
   logic [erpd_pkg::GAIN_W-1:0]         kd_ff, kd_in;

   logic [erpd_pkg::CNT_W-1:0]          last_count_ff, last_count_in;
   logic [erpd_pkg::TIME_W-1:0]         last_time_ff, last_time_in;
   logic signed [erpd_pkg::RPM_W-1:0]   last_speed_ff, last_speed_in;
   logic signed [erpd_pkg::SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [erpd_pkg::ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [erpd_pkg::PWM_W-1:0]   last_pwm_ff, last_pwm_in;
   logic                                pin_a_ff, pin_a_in;
   logic                                pin_b_ff, pin_b_in;

   logic signed [erpd_pkg::CNT_W-1:0]   delta_ff, delta_in;
   logic [erpd_pkg::TIME_W-1:0]         dt_ff, dt_in;
   logic signed [erpd_pkg::RPM_W-1:0]   target_ff, target_in;
   logic signed [erpd_pkg::RPM_W-1:0]   speed_ff, speed_in;
   logic                                zflag_ff, zflag_in;
   logic signed [erpd_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [erpd_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [erpd_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [erpd_pkg::S_W-1:0]     s_ff, s_in;
   logic signed [erpd_pkg::ACC_W-1:0]   xacc_ff, xacc_in;
   logic                                neg_ff, neg_in;
   logic [erpd_pkg::NUM_W-1:0]          num_ff, num_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [erpd_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [erpd_pkg::RSP_USER_W-1:0]     rsp_user_ff, rsp_user_in;

   erpd_pkg::mul_op_type                mul_op;
   logic signed [erpd_pkg::PROD_W-1:0]  prod_ff;
   erpd_pkg::div_req_type               div_req;
   erpd_pkg::div_rsp_type               div_rsp;

   logic [erpd_pkg::CNT_W-1:0]          req_count;
   logic [erpd_pkg::TIME_W-1:0]         req_time;
   logic signed [erpd_pkg::RPM_W-1:0]   req_target;
   logic [erpd_pkg::CPR_W-1:0]          cpr_eff;
   logic [erpd_pkg::MR_W-1:0]           mr_eff;
   logic [erpd_pkg::PROD_W-1:0]         prod_mag;
   logic signed [erpd_pkg::ERR_W-1:0]   err_c;
   logic signed [erpd_pkg::SUM_W:0]     sum_w;
   logic signed [erpd_pkg::SUM_W-1:0]   sum_c;
   logic signed [erpd_pkg::DIFF_W-1:0]  diff_c;
   logic signed [erpd_pkg::ACC_W-1:0]   lim_s;
   logic signed [erpd_pkg::ACC_W-1:0]   lim_x;
   logic signed [erpd_pkg::ACC_W-1:0]   xc;
   logic [erpd_pkg::ACC_W-1:0]          xc_mag;
   logic [erpd_pkg::RPM_W-1:0]          spd_mag;
   logic [erpd_pkg::PWM_W-1:0]          pwm_mag;
   logic signed [erpd_pkg::PWM_W-1:0]   pwm_c;
   logic signed [31:0]                  pwm32;
   logic [31:0]                         pwm_abs32;
   logic [erpd_pkg::DUTY_W-1:0]         duty_c;
   logic                                out_free;

   assign req_count  = req_tdata[31:0];
   assign req_time   = req_tdata[63:32];
   assign req_target = req_tdata[79:64];

   assign cpr_eff = (cpr_ff == '0) ? erpd_pkg::CPR_W'(1) : cpr_ff;
   assign mr_eff  = (mr_ff == '0) ? erpd_pkg::MR_W'(1) : mr_ff;

   assign prod_mag = prod_ff[erpd_pkg::PROD_W-1] ? erpd_pkg::PROD_W'(-prod_ff)
                                                 : erpd_pkg::PROD_W'(prod_ff);

   assign err_c  = erpd_pkg::ERR_W'(target_ff) - erpd_pkg::ERR_W'(speed_ff);
   assign sum_w  = (erpd_pkg::SUM_W + 1)'(error_sum_ff) + (erpd_pkg::SUM_W + 1)'(err_c);
   assign diff_c = erpd_pkg::DIFF_W'(err_c) - erpd_pkg::DIFF_W'(last_error_ff);

   // saturate the integral on signed overflow
   always_comb begin
      if (sum_w[erpd_pkg::SUM_W] != sum_w[erpd_pkg::SUM_W-1]) begin
         sum_c = sum_w[erpd_pkg::SUM_W] ? {1'b1, {(erpd_pkg::SUM_W-1){1'b0}}}
                                        : {1'b0, {(erpd_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_c = sum_w[erpd_pkg::SUM_W-1:0];
      end
   end

   assign lim_s = $signed(erpd_pkg::ACC_W'({mr_eff, 9'b0}));
   assign lim_x = $signed(erpd_pkg::ACC_W'(prod_ff)) <<< 8;

   always_comb begin
      priority if (xacc_ff > lim_x) begin
         xc = lim_x;
      end else if (xacc_ff < -lim_x) begin
         xc = -lim_x;
      end else begin
         xc = xacc_ff;
      end
   end

   assign xc_mag = xc[erpd_pkg::ACC_W-1] ? erpd_pkg::ACC_W'(-xc) : erpd_pkg::ACC_W'(xc);

   assign spd_mag = (div_rsp.ovf || div_rsp.quo[erpd_pkg::QUO_W-1])
                  ? erpd_pkg::RPM_W'(erpd_pkg::SPEED_MAX)
                  : erpd_pkg::RPM_W'(div_rsp.quo);

   assign pwm_mag = erpd_pkg::PWM_W'(div_rsp.quo);
   assign pwm_c   = neg_ff ? -$signed(pwm_mag) : $signed(pwm_mag);

   assign pwm32     = 32'(last_pwm_ff);
   assign pwm_abs32 = pwm32[31] ? 32'(-pwm32) : 32'(pwm32);
   assign duty_c    = (pwm_abs32 > 32'(erpd_pkg::DUTY_MAX))
                    ? erpd_pkg::DUTY_W'(erpd_pkg::DUTY_MAX)
                    : pwm_abs32[erpd_pkg::DUTY_W-1:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == erpd_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cpr_in        = cpr_ff;
      mr_in         = mr_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      last_count_in = last_count_ff;
      last_time_in  = last_time_ff;
      last_speed_in = last_speed_ff;
      error_sum_in  = error_sum_ff;
      last_error_in = last_error_ff;
      last_pwm_in   = last_pwm_ff;
      pin_a_in      = pin_a_ff;
      pin_b_in      = pin_b_ff;
      delta_in      = delta_ff;
      dt_in         = dt_ff;
      target_in     = target_ff;
      speed_in      = speed_ff;
      zflag_in      = zflag_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      acc_in        = acc_ff;
      s_in          = s_ff;
      xacc_in       = xacc_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      mul_op.a      = '0;
      mul_op.b      = '0;
      div_req.start = 1'b0;
      div_req.num   = num_ff;
      div_req.den   = '0;

      if (csr_wen) begin
         unique case (csr_index)
            erpd_pkg::CSR_COUNTS_PER_REV: cpr_in = csr_wdata[erpd_pkg::CPR_W-1:0];
            erpd_pkg::CSR_MAX_RPM:        mr_in  = csr_wdata[erpd_pkg::MR_W-1:0];
            erpd_pkg::CSR_PROP_GAIN:      kp_in  = csr_wdata[erpd_pkg::GAIN_W-1:0];
            erpd_pkg::CSR_INTEG_GAIN:     ki_in  = csr_wdata[erpd_pkg::GAIN_W-1:0];
            erpd_pkg::CSR_DERIV_GAIN:     kd_in  = csr_wdata[erpd_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         erpd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               delta_in      = $signed(req_count - last_count_ff);
               dt_in         = req_time - last_time_ff;
               target_in     = req_target;
               last_count_in = req_count;
               last_time_in  = req_time;
               state_in      = erpd_pkg::ST_SPD_NUM;
            end
         end
         erpd_pkg::ST_SPD_NUM: begin
            mul_op.a = erpd_pkg::MUL_A_W'(delta_ff);
            mul_op.b = erpd_pkg::MUL_B_W'(erpd_pkg::SPEED_SCALE);
            state_in = erpd_pkg::ST_SPD_DEN;
         end
         erpd_pkg::ST_SPD_DEN: begin
            mul_op.a = $signed(erpd_pkg::MUL_A_W'(dt_ff));
            mul_op.b = $signed(erpd_pkg::MUL_B_W'(cpr_eff));
            neg_in   = prod_ff[erpd_pkg::PROD_W-1];
            num_in   = prod_mag[erpd_pkg::NUM_W-1:0];
            state_in = erpd_pkg::ST_SPD_START;
         end
         erpd_pkg::ST_SPD_START: begin
            if (dt_ff == '0) begin
               // no elapsed time: hold the last speed
               speed_in = last_speed_ff;
               zflag_in = 1'b1;
               state_in = erpd_pkg::ST_PID_ERR;
            end else begin
               zflag_in      = 1'b0;
               div_req.start = 1'b1;
               div_req.den   = prod_mag[erpd_pkg::DEN_W-1:0];
               state_in      = erpd_pkg::ST_SPD_WAIT;
            end
         end
         erpd_pkg::ST_SPD_WAIT: begin
            if (div_rsp.done) begin
               speed_in = neg_ff ? -$signed(spd_mag) : $signed(spd_mag);
               state_in = erpd_pkg::ST_PID_ERR;
            end
         end
         erpd_pkg::ST_PID_ERR: begin
            last_speed_in = speed_ff;
            err_in        = err_c;
            error_sum_in  = sum_c;
            diff_in       = diff_c;
            last_error_in = err_c;
            state_in      = erpd_pkg::ST_MUL_P;
         end
         erpd_pkg::ST_MUL_P: begin
            mul_op.a = erpd_pkg::MUL_A_W'(err_ff);
            mul_op.b = $signed(erpd_pkg::MUL_B_W'(kp_ff));
            state_in = erpd_pkg::ST_MUL_I;
         end
         erpd_pkg::ST_MUL_I: begin
            mul_op.a = erpd_pkg::MUL_A_W'(error_sum_ff);
            mul_op.b = $signed(erpd_pkg::MUL_B_W'(ki_ff));
            acc_in   = erpd_pkg::ACC_W'(prod_ff);
            state_in = erpd_pkg::ST_MUL_D;
         end
         erpd_pkg::ST_MUL_D: begin
            mul_op.a = erpd_pkg::MUL_A_W'(diff_ff);
            mul_op.b = $signed(erpd_pkg::MUL_B_W'(kd_ff));
            acc_in   = acc_ff + erpd_pkg::ACC_W'(prod_ff);
            state_in = erpd_pkg::ST_ACC_D;
         end
         erpd_pkg::ST_ACC_D: begin
            acc_in   = acc_ff + erpd_pkg::ACC_W'(prod_ff);
            state_in = erpd_pkg::ST_CLAMP_S;
         end
         erpd_pkg::ST_CLAMP_S: begin
            priority if (acc_ff > lim_s) begin
               s_in = erpd_pkg::S_W'(lim_s);
            end else if (acc_ff < -lim_s) begin
               s_in = erpd_pkg::S_W'(-lim_s);
            end else begin
               s_in = erpd_pkg::S_W'(acc_ff);
            end
            state_in = erpd_pkg::ST_MUL_S;
         end
         erpd_pkg::ST_MUL_S: begin
            mul_op.a = erpd_pkg::MUL_A_W'(s_ff);
            mul_op.b = erpd_pkg::MUL_B_W'(erpd_pkg::PWM_FULL_SCALE);
            state_in = erpd_pkg::ST_MUL_PWM;
         end
         erpd_pkg::ST_MUL_PWM: begin
            mul_op.a = erpd_pkg::MUL_A_W'(last_pwm_ff);
            mul_op.b = $signed(erpd_pkg::MUL_B_W'(mr_eff));
            xacc_in  = erpd_pkg::ACC_W'(prod_ff);
            state_in = erpd_pkg::ST_MUL_LIM;
         end
         erpd_pkg::ST_MUL_LIM: begin
            mul_op.a = $signed(erpd_pkg::MUL_A_W'(mr_eff));
            mul_op.b = erpd_pkg::MUL_B_W'(erpd_pkg::PWM_FULL_SCALE);
            xacc_in  = xacc_ff + (erpd_pkg::ACC_W'(prod_ff) <<< 8);
            state_in = erpd_pkg::ST_CLAMP_X;
         end
         erpd_pkg::ST_CLAMP_X: begin
            neg_in   = xc[erpd_pkg::ACC_W-1];
            num_in   = xc_mag[erpd_pkg::NUM_W-1:0];
            state_in = erpd_pkg::ST_PWM_START;
         end
         erpd_pkg::ST_PWM_START: begin
            div_req.start = 1'b1;
            div_req.den   = erpd_pkg::DEN_W'({mr_eff, 8'b0});
            state_in      = erpd_pkg::ST_PWM_WAIT;
         end
         erpd_pkg::ST_PWM_WAIT: begin
            if (div_rsp.done) begin
               last_pwm_in = pwm_c;
               if (pwm_c != '0) begin
                  pin_a_in = !pwm_c[erpd_pkg::PWM_W-1];
                  pin_b_in = pwm_c[erpd_pkg::PWM_W-1];
               end
               state_in = erpd_pkg::ST_DONE;
            end
         end
         erpd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = erpd_pkg::RSP_DATA_W'({speed_ff, pin_b_ff, pin_a_ff, duty_c,
                                                      pwm32[erpd_pkg::PWM_OUT_W-1:0]});
               rsp_user_in  = zflag_ff;
               state_in     = erpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff        <= erpd_pkg::CPR_RESET;
         mr_ff         <= erpd_pkg::MR_RESET;
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         last_count_ff <= '0;
         last_time_ff  <= '0;
         last_speed_ff <= '0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         last_pwm_ff   <= '0;
         pin_a_ff      <= 1'b0;
         pin_b_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cpr_ff        <= cpr_in;
         mr_ff         <= mr_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         last_count_ff <= last_count_in;
         last_time_ff  <= last_time_in;
         last_speed_ff <= last_speed_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
         last_pwm_ff   <= last_pwm_in;
         pin_a_ff      <= pin_a_in;
         pin_b_ff      <= pin_b_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      delta_ff    <= delta_in;
      dt_ff       <= dt_in;
      target_ff   <= target_in;
      speed_ff    <= speed_in;
      zflag_ff    <= zflag_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      xacc_ff     <= xacc_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   erpd_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod_ff)
   );

   erpd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ERPD_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != erpd_pkg::ST_IDLE)
   `ERPD_ASSERT_IMPLY(a_div_done_waited, clock, reset, div_rsp.done, state_ff == erpd_pkg::ST_SPD_WAIT || state_ff == erpd_pkg::ST_PWM_WAIT)
   `ERPD_ASSERT_IMPLY(a_forward_pins, clock, reset, rsp_valid_ff && !rsp_data_ff[8] && rsp_data_ff[7:0] != 8'd0, rsp_data_ff[17] && !rsp_data_ff[18])
   `ERPD_ASSERT_IMPLY(a_rpm_saturated, clock, reset, rsp_valid_ff, rsp_data_ff[34:19] != 16'h8000)

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 3000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [8:0]  pwm_signed;
      logic [7:0]  duty;
      logic        dir_a;
      logic        dir_b;
      logic [15:0] measured_rpm;
      logic        zero_interval;
   } drive_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [erpd_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [erpd_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [erpd_pkg::RSP_USER_W-1:0]   rsp_tuser;
   logic                              csr_wen = 1'b0;
   logic [erpd_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [erpd_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   encoder_rpm_pid_pwm_drive DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // register copies
   logic [15:0] cfg_cpr     = erpd_pkg::CPR_RESET;
   logic [14:0] cfg_max_rpm = erpd_pkg::MR_RESET;
   longint      gain_p = 0;
   longint      gain_i = 0;
   longint      gain_d = 0;

   // controller state copies
   logic [31:0] prev_count = '0;
   logic [31:0] prev_time  = '0;
   longint      prev_speed = 0;
   longint      err_sum    = 0;
   longint      prev_err   = 0;
   longint      prev_pwm   = 0;
   logic        pin_fwd    = 1'b0;
   logic        pin_rev    = 1'b0;

   drive_result_type pending_drive_q[$];

   int src_gap_pct    = 33;
   int sink_idle_pct  = 33;
   int sink_hold_left = 0;
   int cycle_count    = 0;
   int samples_sent   = 0;
   int responses_seen = 0;
   int setting_count  = 0;
   int mismatch_count = 0;

   function automatic longint clamp_ll(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic drive_result_type predict_drive(input logic [31:0] cnt,
                                                      input logic [31:0] now,
                                                      input logic signed [15:0] tgt);
      drive_result_type r;
      logic [31:0]   dcnt;
      logic [31:0]   dt;
      longint        cpr, mr, delta, dt_l, speed, err, sum, s, x, lim, pwm, mag;
      cpr   = (cfg_cpr == '0) ? 64'sd1 : longint'(cfg_cpr);
      mr    = (cfg_max_rpm == '0) ? 64'sd1 : longint'(cfg_max_rpm);
      dcnt  = cnt - prev_count;
      dt    = now - prev_time;
      delta = longint'($signed(dcnt));
      dt_l  = longint'(dt);
      r.zero_interval = (dt == '0);
      if (dt == '0)
         speed = prev_speed;
      else
         speed = clamp_ll((delta * erpd_pkg::SPEED_SCALE) / (cpr * dt_l),
                          -erpd_pkg::SPEED_MAX, erpd_pkg::SPEED_MAX);
      prev_count = cnt;
      prev_time  = now;
      prev_speed = speed;

      err     = longint'(tgt) - speed;
      sum     = clamp_ll(err_sum + err, -64'sd2147483648, 64'sd2147483647);
      err_sum = sum;
      s = gain_p * err + gain_i * sum + gain_d * (err - prev_err);
      prev_err = err;

      // correction bounded first, then the rpm clamp
      s   = clamp_ll(s, -2 * mr * 256, 2 * mr * 256);
      x   = prev_pwm * mr * 256 + s * erpd_pkg::PWM_FULL_SCALE;
      lim = mr * 256 * erpd_pkg::PWM_FULL_SCALE;
      x   = clamp_ll(x, -lim, lim);
      pwm = x / (256 * mr);
      prev_pwm = pwm;

      if (pwm > 0) begin
         pin_fwd = 1'b1;
         pin_rev = 1'b0;
      end else if (pwm < 0) begin
         pin_fwd = 1'b0;
         pin_rev = 1'b1;
      end
      mag = (pwm < 0) ? -pwm : pwm;
      if (mag > erpd_pkg::DUTY_MAX)
         mag = erpd_pkg::DUTY_MAX;

      r.pwm_signed   = 9'(pwm);
      r.duty         = 8'(mag);
      r.dir_a        = pin_fwd;
      r.dir_b        = pin_rev;
      r.measured_rpm = 16'(speed);
      return r;
   endfunction

   // --- request side, called at a falling edge ---
   task automatic send_sample(input logic [31:0] cnt, input logic [31:0] now,
                              input logic [15:0] tgt);
      while ($urandom_range(99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= erpd_pkg::REQ_DATA_W'({$urandom, $urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tgt, now, cnt};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_drive_q.push_back(predict_drive(cnt, now, tgt));
      samples_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_target(input int span);
      int v;
      v = $urandom_range(2 * span);
      return 16'(v - span);
   endfunction

   task automatic send_noise_sample();
      send_sample($urandom, $urandom, pick_target(erpd_pkg::SPEED_MAX));
   endtask

   // encoder ticks follow the previous drive command, roughly
   task automatic send_plant_sample(input logic [15:0] tgt, input int max_dt);
      longint rpm, ticks, mr_eff, cpr_eff;
      int     dtv, jitter;
      mr_eff  = (cfg_max_rpm == '0) ? 64'sd1 : longint'(cfg_max_rpm);
      cpr_eff = (cfg_cpr == '0) ? 64'sd1 : longint'(cfg_cpr);
      dtv     = ($urandom_range(99) < 6) ? 0 : $urandom_range(max_dt, 1);
      jitter  = $urandom_range(40);
      rpm     = prev_pwm * mr_eff / erpd_pkg::PWM_FULL_SCALE + jitter - 20;
      ticks   = rpm * cpr_eff * dtv / erpd_pkg::SPEED_SCALE;
      send_sample(prev_count + 32'(ticks), prev_time + 32'(dtv), tgt);
   endtask

   task automatic run_loop(input int n_items);
      logic [15:0] tgt;
      int          span;
      span = cfg_max_rpm + cfg_max_rpm / 4 + 1;
      if (span > erpd_pkg::SPEED_MAX)
         span = erpd_pkg::SPEED_MAX;
      tgt = pick_target(span);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(29) == 0)
            tgt = ($urandom_range(3) == 0) ? pick_target(erpd_pkg::SPEED_MAX)
                                           : pick_target(span);
         if ($urandom_range(9) == 0)
            send_noise_sample();
         else
            send_plant_sample(tgt, 40);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_drive_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [erpd_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         erpd_pkg::CSR_COUNTS_PER_REV: cfg_cpr = val;
         erpd_pkg::CSR_MAX_RPM:        cfg_max_rpm = val[14:0];
         erpd_pkg::CSR_PROP_GAIN:      gain_p = longint'(val);
         erpd_pkg::CSR_INTEG_GAIN:     gain_i = longint'(val);
         erpd_pkg::CSR_DERIV_GAIN:     gain_d = longint'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [15:0] cpr, input logic [15:0] mr,
                               input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd);
      settle();
      write_reg(erpd_pkg::CSR_COUNTS_PER_REV, cpr);
      write_reg(erpd_pkg::CSR_MAX_RPM, mr);
      write_reg(erpd_pkg::CSR_PROP_GAIN, kp);
      write_reg(erpd_pkg::CSR_INTEG_GAIN, ki);
      write_reg(erpd_pkg::CSR_DERIV_GAIN, kd);
      setting_count++;
   endtask

   // --- response side ---
   always @(negedge clock) begin
      if (sink_hold_left > 0) begin
         sink_hold_left = sink_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch at response %0d: %s expected %0h got %0h",
                  responses_seen, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : check_responses
      drive_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pwm_signed    = rsp_tdata[8:0];
         got.duty          = rsp_tdata[16:9];
         got.dir_a         = rsp_tdata[17];
         got.dir_b         = rsp_tdata[18];
         got.measured_rpm  = rsp_tdata[34:19];
         got.zero_interval = rsp_tuser[0];
         if (pending_drive_q.size() == 0) begin
            note_mismatch("unexpected response", '0, rsp_tdata[31:0]);
         end else begin
            want = pending_drive_q.pop_front();
            if (got.pwm_signed !== want.pwm_signed)
               note_mismatch("pwm_signed", 32'(want.pwm_signed), 32'(got.pwm_signed));
            if (got.duty !== want.duty)
               note_mismatch("duty", 32'(want.duty), 32'(got.duty));
            if (got.dir_a !== want.dir_a)
               note_mismatch("dir_a", 32'(want.dir_a), 32'(got.dir_a));
            if (got.dir_b !== want.dir_b)
               note_mismatch("dir_b", 32'(want.dir_b), 32'(got.dir_b));
            if (got.measured_rpm !== want.measured_rpm)
               note_mismatch("measured_rpm", 32'(want.measured_rpm), 32'(got.measured_rpm));
            if (got.zero_interval !== want.zero_interval)
               note_mismatch("zero_interval", 32'(want.zero_interval),
                             32'(got.zero_interval));
         end
         responses_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // --- tests ---
   task automatic test_reset_defaults();
      send_sample(32'h0000_0000, 32'h0000_0000, 16'sd0);
      send_sample(32'h7FFF_FFFF, 32'h0000_0001, 16'sd32767);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF, -16'sd32767);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF, 16'sd0);
   endtask

   // unit gain at full scale 255: pwm steps by the error, zero pwm keeps the pins
   task automatic test_direction_hold();
      apply_config(16'd1000, 16'd255, 16'd256, 16'd0, 16'd0);
      send_sample(prev_count, prev_time + 32'd10, 16'sd0);
      send_sample(prev_count, prev_time, 16'sd100);
      send_sample(prev_count, prev_time, -16'sd100);
      send_sample(prev_count, prev_time, -16'sd50);
      send_sample(prev_count, prev_time, 16'sd50);
      send_sample(prev_count, prev_time, 16'sd32767);
      send_sample(prev_count, prev_time, -16'sd32767);
      send_sample(prev_count, prev_time, 16'sd0);
      send_sample(prev_count, prev_time, 16'sd0);
   endtask

   task automatic test_count_time_wrap();
      apply_config(16'd1, 16'd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(32'hFFFF_FFF0, prev_time + 32'd1, 16'sd32767);
      send_sample(32'h0000_0010, prev_time + 32'd1, -16'sd32767);
      send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFE, 16'sd0);
      send_sample(32'h8000_0001, 32'h0000_0003, 16'sd1);
      send_sample(32'h8000_0001, 32'h0000_0003, -16'sd1);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 16'sd32767);
      send_sample(32'h0000_0000, 32'h0000_0000, 16'sd32767);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, -16'sd32767);
   endtask

   task automatic register_phase(input logic [15:0] cpr, input logic [15:0] mr,
                                 input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd);
      apply_config(cpr, mr, kp, ki, kd);
      run_loop(12);
   endtask

   task automatic test_register_extremes();
      register_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      register_phase(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      register_phase(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'd0, 16'd0);
      register_phase(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      register_phase(erpd_pkg::CPR_RESET, 16'(erpd_pkg::MR_RESET), 16'd0, 16'd0, 16'hFFFF);
      settle();
      for (int i = erpd_pkg::CSR_DERIV_GAIN + 1; i < (1 << erpd_pkg::CSR_IDX_W); i++)
         write_reg(erpd_pkg::CSR_IDX_W'(i), 16'($urandom));
      register_phase(16'h5555, 16'h2AAA, 16'hAAAA, 16'h5555, 16'hAAAA);
   endtask

   task automatic test_closed_loop_random();
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 5)
            apply_config(16'($urandom_range(4096, 1)), 16'($urandom_range(3000, 20)),
                         16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         16'($urandom_range(65535)));
         else
            apply_config(16'($urandom_range(4096, 1)), 16'($urandom_range(3000, 20)),
                         16'($urandom_range(2048)), 16'($urandom_range(256)),
                         16'($urandom_range(1024)));
         // one stretch with neither side idling
         src_gap_pct   = (ph == 3) ? 0 : 33;
         sink_idle_pct = (ph == 3) ? 0 : 33;
         run_loop(210);
      end
      src_gap_pct   = 33;
      sink_idle_pct = 33;
   endtask

   task automatic test_noise_samples();
      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < 150; i++)
         send_noise_sample();
   endtask

   task automatic test_output_stall();
      apply_config(16'd512, 16'd600, 16'd300, 16'd20, 16'd100);
      sink_hold_left = HOLD_CYCLES;
      run_loop(60);
   endtask

   task automatic test_drain_pause();
      run_loop(20);
      settle();
      run_loop(20);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_direction_hold();
      test_count_time_wrap();
      test_register_extremes();
      test_closed_loop_random();
      test_noise_samples();
      test_output_stall();
      test_drain_pause();
      settle();

      $display("checked %0d drive responses from %0d samples over %0d register settings",
               responses_seen, samples_sent, setting_count);
      $display("covered wraps, zero intervals, saturation, noise and a %0d-cycle stall",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  pending_drive_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: encoder_rpm_pid_pwm_drive.f
+incdir+rtl/core
rtl/core/erpd_pkg.sv
rtl/core/erpd_mul.sv
rtl/core/erpd_div.sv
rtl/core/encoder_rpm_pid_pwm_drive.sv
test/tb.sv
